FILE: rtl/page_reader_writer_lock_table_assert.svh
// assertion macros for the page lock table
// used by prwl_ctrl; no other dependencies
`ifndef PAGE_READER_WRITER_LOCK_TABLE_ASSERT_SVH
`define PAGE_READER_WRITER_LOCK_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define PRWL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PRWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/prwl_pkg.sv
// shared types and constants of the page lock table
// no dependencies
`default_nettype none

package prwl_pkg;

    localparam int FUNC_W     = 2;
    localparam int LPN_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 6;
    localparam int LOCKS_W    = 7;
    localparam int CNT_W      = 8;
    localparam int ENTRY_W    = LPN_W + CNT_W;
    localparam int LOCK_SLOTS = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ_LOCK    = 2'd0,
        FN_WRITE_LOCK   = 2'd1,
        FN_READ_UNLOCK  = 2'd2,
        FN_WRITE_UNLOCK = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 2'd0,
        ST_DENIED     = 2'd1,
        ST_UNLOCKED   = 2'd2,
        ST_UNLOCK_ERR = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/prwl_mem.sv
// slot memory: page key and reader count per slot, one write and one read port
// registered read data; uses prwl_pkg
`default_nettype none

module prwl_mem #(
    parameter int LOCK_SLOTS = prwl_pkg::LOCK_SLOTS,
    parameter int IDX_W      = $clog2(LOCK_SLOTS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [IDX_W-1:0]             i_waddr,
    input  wire logic [prwl_pkg::ENTRY_W-1:0] i_wdata,
    input  wire logic [IDX_W-1:0]             i_raddr,
    output logic      [prwl_pkg::ENTRY_W-1:0] o_rdata
);
    import prwl_pkg::*;

    logic [ENTRY_W-1:0] r_mem [LOCK_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/prwl_ctrl.sv
// request sequencer: slot scan, lock decision, write-back and result beat
// uses prwl_pkg and page_reader_writer_lock_table_assert.svh
`default_nettype none

module prwl_ctrl #(
    parameter int LOCK_SLOTS = prwl_pkg::LOCK_SLOTS,
    parameter int IDX_W      = $clog2(LOCK_SLOTS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [prwl_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [prwl_pkg::LPN_W-1:0]    i_lpn,
    output logic                               busy,
    output logic                               o_valid,
    output logic      [prwl_pkg::STATUS_W-1:0] o_status,
    output logic      [prwl_pkg::SLOT_W-1:0]   o_slot,
    output logic      [prwl_pkg::LOCKS_W-1:0]  o_locks_in_use,
    // memory side
    output logic                               o_mem_we,
    output logic      [IDX_W-1:0]              o_mem_waddr,
    output logic      [prwl_pkg::ENTRY_W-1:0]  o_mem_wdata,
    output logic      [IDX_W-1:0]              o_mem_raddr,
    input  wire logic [prwl_pkg::ENTRY_W-1:0]  i_mem_rdata
);
    import prwl_pkg::*;

    localparam int USED_W = $clog2(LOCK_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    t_state              r_state;
    t_func               r_func;
    logic [LPN_W-1:0]    r_lpn;
    logic [IDX_W-1:0]    r_addr;
    logic                r_rd_pend;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;
    logic [LOCK_SLOTS-1:0] r_valid;
    logic [USED_W-1:0]   r_used;
    logic                r_res_valid;
    t_status             r_status;
    logic [IDX_W-1:0]    r_res_slot;

    logic [LPN_W-1:0]    rd_key;
    logic [CNT_W-1:0]    rd_cnt;
    logic                chk_hit;
    logic                chk_free;

    // decision outputs
    t_status             n_status;
    logic [IDX_W-1:0]    n_slot;
    logic                n_we;
    logic [IDX_W-1:0]    n_waddr;
    logic [CNT_W-1:0]    n_wcnt;
    logic                n_set;
    logic                n_clr;

    assign rd_key = i_mem_rdata[ENTRY_W-1:CNT_W];
    assign rd_cnt = i_mem_rdata[CNT_W-1:0];

    // lowest matching valid slot and lowest free slot, one entry per cycle
    assign chk_hit  = r_rd_pend && r_valid[r_rd_idx] && (rd_key == r_lpn) && !r_hit_found;
    assign chk_free = r_rd_pend && !r_valid[r_rd_idx] && !r_free_found;

    always_comb begin
        n_status = ST_DENIED;
        n_slot   = '0;
        n_we     = 1'b0;
        n_waddr  = r_hit_idx;
        n_wcnt   = r_hit_cnt;
        n_set    = 1'b0;
        n_clr    = 1'b0;
        unique case (r_func)
            FN_READ_LOCK: begin
                if (!r_hit_found) begin
                    if (r_free_found) begin
                        n_status = ST_GRANTED;
                        n_slot   = r_free_idx;
                        n_we     = 1'b1;
                        n_waddr  = r_free_idx;
                        n_wcnt   = CNT_W'(1);
                        n_set    = 1'b1;
                    end
                end else begin
                    n_slot = r_hit_idx;
                    if (r_hit_cnt != '0 && r_hit_cnt != CNT_MAX) begin
                        n_status = ST_GRANTED;
                        n_we     = 1'b1;
                        n_wcnt   = r_hit_cnt + CNT_W'(1);
                    end
                end
            end
            FN_WRITE_LOCK: begin
                if (r_hit_found) begin
                    n_slot = r_hit_idx;
                end else if (r_free_found) begin
                    n_status = ST_GRANTED;
                    n_slot   = r_free_idx;
                    n_we     = 1'b1;
                    n_waddr  = r_free_idx;
                    n_wcnt   = '0;
                    n_set    = 1'b1;
                end
            end
            FN_READ_UNLOCK: begin
                n_status = ST_UNLOCK_ERR;
                if (r_hit_found) begin
                    n_slot = r_hit_idx;
                    if (r_hit_cnt != '0) begin
                        n_status = ST_UNLOCKED;
                        n_we     = 1'b1;
                        n_wcnt   = r_hit_cnt - CNT_W'(1);
                        n_clr    = (r_hit_cnt == CNT_W'(1));
                    end
                end
            end
            FN_WRITE_UNLOCK: begin
                n_status = ST_UNLOCK_ERR;
                if (r_hit_found) begin
                    n_slot = r_hit_idx;
                    if (r_hit_cnt == '0) begin
                        n_status = ST_UNLOCKED;
                        n_clr    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_pend    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_used       <= '0;
            r_res_valid  <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_res_valid <= (r_state == S_DECIDE);
            if (chk_hit) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_cnt   <= rd_cnt;
            end
            if (chk_free) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func       <= t_func'(i_func);
                        r_lpn        <= i_lpn;
                        r_addr       <= '0;
                        r_rd_pend    <= 1'b0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= 1'b1;
                    r_rd_idx  <= r_addr;
                    r_addr    <= r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last read data is checked on this edge
                    r_rd_pend <= 1'b0;
                    r_state   <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_status    <= n_status;
                    r_res_slot  <= n_slot;
                    if (n_set) begin
                        r_valid[n_waddr] <= 1'b1;
                        r_used           <= r_used + USED_W'(1);
                    end else if (n_clr) begin
                        r_valid[n_waddr] <= 1'b0;
                        r_used           <= r_used - USED_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_res_valid;
    assign o_status       = r_status;
    assign o_slot         = SLOT_W'(r_res_slot);
    assign o_locks_in_use = LOCKS_W'(r_used);

    assign o_mem_we    = (r_state == S_DECIDE) && n_we;
    assign o_mem_waddr = n_waddr;
    assign o_mem_wdata = {r_lpn, n_wcnt};
    assign o_mem_raddr = r_addr;

`include "page_reader_writer_lock_table_assert.svh"

    `PRWL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted beat did not raise busy")
    `PRWL_ASSERT_NOW(a_grant_valid, i_clk, i_rst_n,
        r_res_valid && (r_status == ST_GRANTED), r_valid[r_res_slot],
        "granted slot is not marked valid")
    `PRWL_ASSERT_NOW(a_used_count, i_clk, i_rst_n, 1'b1,
        $countones(r_valid) == int'(r_used),
        "slot count does not match valid bits")
    `PRWL_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, r_res_valid, !busy,
        "result beat while a request is in flight")

endmodule

`default_nettype wire

FILE: rtl/page_reader_writer_lock_table.sv
// Page reader/writer lock table. A request is taken when start is high and
// busy is low; it then scans every slot of the slot memory, one read per
// cycle through its single read port, decides, writes back at most one slot
// and shows one result beat on o_valid for a single cycle. The receiver
// cannot stall that beat. No new request is accepted while busy is high; a
// new request may be accepted in the cycle the result is shown.
// top level; uses prwl_pkg, prwl_mem and prwl_ctrl
`default_nettype none

module page_reader_writer_lock_table #(
    parameter int LOCK_SLOTS = prwl_pkg::LOCK_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [prwl_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [prwl_pkg::LPN_W-1:0]    i_lpn,
    output logic                               busy,
    output logic                               o_valid,
    output logic      [prwl_pkg::STATUS_W-1:0] o_status,
    output logic      [prwl_pkg::SLOT_W-1:0]   o_slot,
    output logic      [prwl_pkg::LOCKS_W-1:0]  o_locks_in_use
);
    import prwl_pkg::*;

    localparam int IDX_W = $clog2(LOCK_SLOTS);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    prwl_ctrl #(
        .LOCK_SLOTS (LOCK_SLOTS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_func         (i_func),
        .i_lpn          (i_lpn),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_locks_in_use (o_locks_in_use),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    prwl_mem #(
        .LOCK_SLOTS (LOCK_SLOTS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: tb/page_reader_writer_lock_table_tb.sv
// self-checking testbench for the page reader/writer lock table
// depends on prwl_pkg and page_reader_writer_lock_table; a built-in lock table
// predictor checks every result beat against the request stream

module page_reader_writer_lock_table_tb;

    import prwl_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 80;
    localparam int REPORT_FIRST = 10;
    localparam int POOL_SIZE    = 10;
    localparam int FILL_PAGES   = LOCK_SLOTS + 2;

    typedef struct packed {
        t_func             func;
        logic [LPN_W-1:0]  lpn;
    } t_lock_request;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [LOCKS_W-1:0]  locks;
    } t_lock_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [LPN_W-1:0]     i_lpn = '0;
    logic                 busy;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic [LOCKS_W-1:0]   o_locks_in_use;

    // shadow lock table
    logic               page_held [LOCK_SLOTS];
    logic [LPN_W-1:0]   page_key  [LOCK_SLOTS];
    logic [CNT_W-1:0]   readers   [LOCK_SLOTS];
    logic [LOCKS_W-1:0] slots_in_use = '0;

    t_lock_request pending_requests[$];
    t_lock_result  expected_results[$];

    int total_requests = 0;
    int beats_sent     = 0;
    int failures       = 0;
    int cycle_count    = 0;
    int idle_left      = 0;
    int peak_in_use    = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    page_reader_writer_lock_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_func         (i_func),
        .i_lpn          (i_lpn),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_locks_in_use (o_locks_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lock_result apply_lock_request(t_lock_request req);
        t_lock_result res;
        int hit;
        int vacant;
        hit    = -1;
        vacant = -1;
        // downward scan leaves the lowest match and the lowest free slot
        for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
            if (page_held[i] && page_key[i] == req.lpn) hit = i;
            if (!page_held[i]) vacant = i;
        end
        res.status = ST_DENIED;
        res.slot   = '0;
        case (req.func)
            FN_READ_LOCK, FN_WRITE_LOCK: begin
                if (hit >= 0) begin
                    res.slot = SLOT_W'(hit);
                    if (req.func == FN_READ_LOCK && readers[hit] != '0 &&
                        readers[hit] != CNT_MAX) begin
                        readers[hit] = readers[hit] + 1'b1;
                        res.status = ST_GRANTED;
                    end
                end else if (vacant >= 0) begin
                    page_held[vacant] = 1'b1;
                    page_key[vacant]  = req.lpn;
                    readers[vacant]   = (req.func == FN_READ_LOCK) ? CNT_W'(1) : '0;
                    slots_in_use      = slots_in_use + 1'b1;
                    res.slot   = SLOT_W'(vacant);
                    res.status = ST_GRANTED;
                end
            end
            default: begin
                res.status = ST_UNLOCK_ERR;
                if (hit >= 0) begin
                    res.slot = SLOT_W'(hit);
                    if (req.func == FN_READ_UNLOCK && readers[hit] != '0) begin
                        readers[hit] = readers[hit] - 1'b1;
                        res.status = ST_UNLOCKED;
                    end else if (req.func == FN_WRITE_UNLOCK && readers[hit] == '0) begin
                        res.status = ST_UNLOCKED;
                    end
                    if (res.status == ST_UNLOCKED && readers[hit] == '0) begin
                        page_held[hit] = 1'b0;
                        slots_in_use   = slots_in_use - 1'b1;
                    end
                end
            end
        endcase
        res.locks = slots_in_use;
        return res;
    endfunction

    function automatic void queue_request(t_func f, logic [LPN_W-1:0] page);
        t_lock_request req;
        req.func = f;
        req.lpn  = page;
        pending_requests.push_back(req);
    endfunction

    // request driver: one beat per start/!busy edge, random idle bursts
    always @(posedge i_clk) begin : driver
        t_lock_request req;
        logic          idling_on;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                req = pending_requests.pop_front();
                expected_results.push_back(apply_lock_request(req));
                beats_sent++;
            end
            // no idling in every third block of 40 beats, nor near the end
            idling_on = (beats_sent < total_requests - 60) && ((beats_sent / 40) % 3 != 2);
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (idling_on && pending_requests.size() != 0 &&
                         $urandom_range(0, 15) == 0) begin
                idle_left = $urandom_range(1, 14) - 1;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                start  <= 1'b1;
                i_func <= pending_requests[0].func;
                i_lpn  <= pending_requests[0].lpn;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_lock_result want;
        if (i_rst_n && o_valid) begin
            status_seen[o_status]++;
            if (int'(o_locks_in_use) > peak_in_use) peak_in_use = o_locks_in_use;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_FIRST)
                    $display("unexpected result beat: status %0d slot %0d locks %0d",
                             o_status, o_slot, o_locks_in_use);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_slot !== want.slot ||
                    o_locks_in_use !== want.locks) begin
                    failures++;
                    if (failures <= REPORT_FIRST)
                        $display("mismatch: expected status %0d slot %0d locks %0d, got %0d %0d %0d",
                                 want.status, want.slot, want.locks,
                                 o_status, o_slot, o_locks_in_use);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("page_reader_writer_lock_table_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        logic [LPN_W-1:0] pool [POOL_SIZE];
        logic [LPN_W-1:0] fill_pages [FILL_PAGES];
        logic [LPN_W-1:0] hot_page;

        for (int i = 0; i < LOCK_SLOTS; i++) begin
            page_held[i] = 1'b0;
            page_key[i]  = '0;
            readers[i]   = '0;
        end

        // directed: every operation, both lock kinds colliding, wrong-kind and
        // absent unlocks, lowest free slot reuse, lpn extremes
        queue_request(FN_READ_LOCK,    32'h0000_0000);
        queue_request(FN_READ_LOCK,    32'h0000_0000);
        queue_request(FN_WRITE_LOCK,   32'h0000_0000);
        queue_request(FN_WRITE_LOCK,   32'hFFFF_FFFF);
        queue_request(FN_READ_LOCK,    32'hFFFF_FFFF);
        queue_request(FN_READ_UNLOCK,  32'hFFFF_FFFF);
        queue_request(FN_WRITE_UNLOCK, 32'h0000_0000);
        queue_request(FN_READ_UNLOCK,  32'h1234_5678);
        queue_request(FN_WRITE_UNLOCK, 32'hA5A5_A5A5);
        queue_request(FN_READ_UNLOCK,  32'h0000_0000);
        queue_request(FN_READ_UNLOCK,  32'h0000_0000);
        queue_request(FN_READ_LOCK,    32'h5555_5555);
        queue_request(FN_WRITE_UNLOCK, 32'hFFFF_FFFF);
        queue_request(FN_WRITE_UNLOCK, 32'hFFFF_FFFF);
        queue_request(FN_WRITE_LOCK,   32'hAAAA_AAAA);
        queue_request(FN_READ_UNLOCK,  32'h5555_5555);
        queue_request(FN_WRITE_UNLOCK, 32'hAAAA_AAAA);

        // small page pool so requests keep hitting the same slots
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;
        for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 6) == 0)
                queue_request(t_func'($urandom_range(0, 3)), $urandom);
            else
                queue_request(t_func'($urandom_range(0, 3)), pool[$urandom_range(0, POOL_SIZE - 1)]);
        end

        // fill the table past capacity, poke at it while full, then drain
        for (int i = 0; i < FILL_PAGES; i++) begin
            fill_pages[i] = $urandom;
            queue_request(FN_WRITE_LOCK, fill_pages[i]);
        end
        queue_request(FN_READ_LOCK, $urandom);
        queue_request(FN_READ_LOCK, $urandom);
        for (int i = 0; i < 30; i++)
            queue_request(t_func'($urandom_range(0, 3)), fill_pages[$urandom_range(0, FILL_PAGES - 1)]);
        for (int i = 0; i < FILL_PAGES; i++)
            queue_request(FN_WRITE_UNLOCK, fill_pages[i]);

        // drive one reader count into saturation
        hot_page = $urandom;
        for (int i = 0; i < 257; i++) queue_request(FN_READ_LOCK, hot_page);
        queue_request(FN_WRITE_UNLOCK, hot_page);
        queue_request(FN_WRITE_LOCK, hot_page);
        for (int i = 0; i < 3; i++) queue_request(FN_READ_UNLOCK, hot_page);
        queue_request(FN_READ_LOCK, hot_page);

        for (int i = 0; i < 60; i++)
            queue_request(t_func'($urandom_range(0, 3)), pool[$urandom_range(0, POOL_SIZE - 1)]);

        total_requests = pending_requests.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d lock requests: %0d granted, %0d denied, %0d unlocked, %0d unlock errors",
                 beats_sent, status_seen[ST_GRANTED], status_seen[ST_DENIED],
                 status_seen[ST_UNLOCKED], status_seen[ST_UNLOCK_ERR]);
        $display("peak occupancy %0d of %0d slots, %0d failures",
                 peak_in_use, LOCK_SLOTS, failures);
        if (failures == 0) begin
            $display("page_reader_writer_lock_table_tb OK");
        end else begin
            $display("page_reader_writer_lock_table_tb NOT OK");
        end
        $finish;
    end

endmodule
